// ===== rtl/fbsp_pkg.sv =====
// Package for the configuration file section parser: types, codes and the preamble table.
`default_nettype none

package fbsp_pkg;

  // Parse phase of the section parser
  typedef enum logic [2:0] {
    PH_PREAMBLE,
    PH_KEY,
    PH_LEN,
    PH_PAYLOAD,
    PH_STOP
  } phase_e;

  // Class of one input byte
  typedef enum logic [2:0] {
    CL_PREAMBLE,
    CL_KEY,
    CL_LEN,
    CL_PAYLOAD,
    CL_IGNORED,
    CL_END
  } class_e;

  // Parser status
  typedef enum logic [1:0] {
    ST_RUN,
    ST_MISMATCH,
    ST_TRUNC,
    ST_DONE
  } status_e;

  localparam logic [3:0] PreambleLen   = 4'd13;
  localparam logic [3:0] PreambleLast  = 4'd12;
  localparam logic [7:0] KeyE          = 8'h65;
  localparam logic [2:0] LenBytesE     = 3'd4;
  localparam logic [2:0] LenBytesOther = 3'd2;

  // One result item
  typedef struct packed {
    class_e      byte_class;
    logic [7:0]  section_key;
    logic [7:0]  data_byte;
    logic        section_last;
    logic [31:0] section_length;
    status_e     status;
  } result_t;

  // Parser state seen by the top level
  typedef struct packed {
    phase_e  phase;
    status_e status;
  } step_stat_t;

  // Expected preamble byte at a given position
  function automatic logic [7:0] preamble_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h00;
      4'd1:    b = 8'h09;
      4'd2:    b = 8'h0f;
      4'd3:    b = 8'hf0;
      4'd4:    b = 8'h0f;
      4'd5:    b = 8'hf0;
      4'd6:    b = 8'h0f;
      4'd7:    b = 8'hf0;
      4'd8:    b = 8'h0f;
      4'd9:    b = 8'hf0;
      4'd10:   b = 8'h00;
      4'd11:   b = 8'h00;
      4'd12:   b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fpga_bitfile_section_parser.sv =====
// Top level of the configuration file section parser.
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_ready_o   | kind_i, byte_in_i
//  out     | output    | out_valid_o / out_ready_i | byte_class_o .. status_o
//
// One item per cycle sustained while in_ready_o is high; each accepted item yields one
// result item from the parser state update, registered in the output or skid entry.
// Reset returns the parser to the preamble phase and empties the result buffer.
// A two-entry result buffer absorbs a stall: in_ready_o falls only when both
// entries hold results not yet taken, and it is driven from a register.
`default_nettype none

module fpga_bitfile_section_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        kind_i,
  input  wire logic [7:0]  byte_in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       byte_class_o,
  output logic [7:0]       section_key_o,
  output logic [7:0]       data_byte_o,
  output logic             section_last_o,
  output logic [31:0]      section_length_o,
  output logic [1:0]       status_o
);
  import fbsp_pkg::*;

  logic       accept;
  result_t    step_res;
  result_t    out_res;
  step_stat_t stat;

  assign accept = in_valid_i && in_ready_o;

  // Parser state and per-byte labeling
  fbsp_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .kind_i   (kind_i),
    .byte_i   (byte_in_i),
    .result_o (step_res),
    .stat_o   (stat)
  );

  // Result buffering
  fbsp_out_buf u_out_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (step_res),
    .pop_valid_o  (out_valid_o),
    .pop_ready_i  (out_ready_i),
    .pop_data_o   (out_res)
  );

  // Unpack the result item onto the ports
  assign byte_class_o     = out_res.byte_class;
  assign section_key_o    = out_res.section_key;
  assign data_byte_o      = out_res.data_byte;
  assign section_last_o   = out_res.section_last;
  assign section_length_o = out_res.section_length;
  assign status_o         = out_res.status;

  // A final status always comes with the stopped phase
  a_status_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.status != ST_RUN) |-> (stat.phase == PH_STOP))
    else $error("final status set outside stop phase");

  // A final status never changes once set
  a_status_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.status != ST_RUN) |=> $stable(stat.status))
    else $error("final status changed after being set");

  // Only payload items carry data or the last flag
  a_payload_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_res.byte_class != CL_PAYLOAD)) |->
      ((out_res.data_byte == 8'h00) && !out_res.section_last))
    else $error("data or last flag on a non-payload item");

  // Input stalls only while a result is waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

endmodule

`default_nettype wire

// ===== rtl/fbsp_step.sv =====
// Parser state registers and the per-byte update that labels each item.
`default_nettype none

module fbsp_step (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  accept_i,
  input  wire logic                  kind_i,
  input  wire logic [7:0]            byte_i,
  output fbsp_pkg::result_t          result_o,
  output fbsp_pkg::step_stat_t       stat_o
);
  import fbsp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  pre_idx_q, pre_idx_d;
  logic [7:0]  key_q, key_d;
  logic [2:0]  len_left_q, len_left_d;
  logic [31:0] len_acc_q, len_acc_d;
  logic [31:0] pay_left_q, pay_left_d;
  status_e     status_q, status_d;

  logic [31:0] pay_dec;
  logic [2:0]  len_dec;
  logic [31:0] acc_shift;
  logic        pre_ok;

  // Shared arithmetic for the update and the result
  assign pay_dec   = (pay_left_q != 32'd0) ? pay_left_q - 32'd1 : 32'd0;
  assign len_dec   = (len_left_q != 3'd0) ? len_left_q - 3'd1 : 3'd0;
  assign acc_shift = {len_acc_q[23:0], byte_i};
  assign pre_ok    = (pre_idx_q < PreambleLen) && (byte_i == preamble_byte(pre_idx_q));

  // Next parser state
  always_comb begin
    phase_d    = phase_q;
    pre_idx_d  = pre_idx_q;
    key_d      = key_q;
    len_left_d = len_left_q;
    len_acc_d  = len_acc_q;
    pay_left_d = pay_left_q;
    status_d   = status_q;
    if (kind_i) begin
      if (phase_q != PH_STOP) begin
        status_d = ST_TRUNC;
        phase_d  = PH_STOP;
      end
    end else begin
      case (phase_q)
        PH_PREAMBLE: begin
          if (!pre_ok) begin
            status_d = ST_MISMATCH;
            phase_d  = PH_STOP;
          end else begin
            pre_idx_d = pre_idx_q + 4'd1;
            if (pre_idx_q == PreambleLast) begin
              phase_d = PH_KEY;
            end
          end
        end
        PH_KEY: begin
          key_d      = byte_i;
          len_left_d = (byte_i == KeyE) ? LenBytesE : LenBytesOther;
          len_acc_d  = 32'd0;
          phase_d    = PH_LEN;
        end
        PH_LEN: begin
          len_acc_d  = acc_shift;
          len_left_d = len_dec;
          if (len_dec == 3'd0) begin
            if (acc_shift == 32'd0) begin
              // empty section: skip straight to the next key, or finish on an e section
              if (key_q == KeyE) begin
                status_d = ST_DONE;
                phase_d  = PH_STOP;
              end else begin
                phase_d = PH_KEY;
              end
            end else begin
              pay_left_d = acc_shift;
              phase_d    = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          pay_left_d = pay_dec;
          if (pay_dec == 32'd0) begin
            if (key_q == KeyE) begin
              status_d = ST_DONE;
              phase_d  = PH_STOP;
            end else begin
              phase_d = PH_KEY;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result item for the byte at the input
  always_comb begin
    result_o                = '0;
    result_o.section_key    = key_d;
    result_o.section_length = len_acc_d;
    result_o.status         = status_d;
    result_o.byte_class     = CL_IGNORED;
    if (kind_i) begin
      result_o.byte_class = CL_END;
    end else begin
      case (phase_q)
        PH_PREAMBLE: result_o.byte_class = CL_PREAMBLE;
        PH_KEY:      result_o.byte_class = CL_KEY;
        PH_LEN:      result_o.byte_class = CL_LEN;
        PH_PAYLOAD: begin
          result_o.byte_class = CL_PAYLOAD;
          result_o.data_byte  = byte_i;
          if (pay_dec == 32'd0) begin
            result_o.section_last = 1'b1;
            // terminate non-e sections as a string
            if (key_q != KeyE) begin
              result_o.data_byte = 8'h00;
            end
          end
        end
        default: result_o.byte_class = CL_IGNORED;
      endcase
    end
  end

  assign stat_o.phase  = phase_q;
  assign stat_o.status = status_q;

  // Advance state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_PREAMBLE;
      pre_idx_q  <= 4'd0;
      key_q      <= 8'd0;
      len_left_q <= 3'd0;
      len_acc_q  <= 32'd0;
      pay_left_q <= 32'd0;
      status_q   <= ST_RUN;
    end else if (accept_i) begin
      phase_q    <= phase_d;
      pre_idx_q  <= pre_idx_d;
      key_q      <= key_d;
      len_left_q <= len_left_d;
      len_acc_q  <= len_acc_d;
      pay_left_q <= pay_left_d;
      status_q   <= status_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fbsp_out_buf.sv =====
// Two-entry result buffer: output register plus skid entry with registered ready.
`default_nettype none

module fbsp_out_buf (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_valid_i,
  output logic              push_ready_o,
  input  fbsp_pkg::result_t push_data_i,
  output logic              pop_valid_o,
  input  wire logic         pop_ready_i,
  output fbsp_pkg::result_t pop_data_o
);
  import fbsp_pkg::*;

  logic    main_valid_q, main_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t main_q, main_d;
  result_t skid_q, skid_d;
  logic    push, pop;

  assign push_ready_o = !skid_valid_q;
  assign pop_valid_o  = main_valid_q;
  assign pop_data_o   = main_q;
  assign push         = push_valid_i && !skid_valid_q;
  assign pop          = main_valid_q && pop_ready_i;

  // Steer items between the output register and the skid entry
  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_d       = main_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        main_d       = skid_q;
        skid_valid_d = 1'b0;
      end else if (push) begin
        main_d = push_data_i;
      end else begin
        main_valid_d = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_q) begin
        main_d       = push_data_i;
        main_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  // Clear valid flags under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire
